[rtl/mqf_pkg.sv]
// Package for the multi-queue FIFO bank: field widths, operation and
// status codes, default sizes. No dependencies.
package mqf_pkg;

   // default bank geometry
   localparam int NUM_QUEUES_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   // fixed beat field widths
   localparam int MODE_W   = 1;
   localparam int QIDX_W   = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;

   // capacity register reset value
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ENQ = 1'b0;
   localparam logic [MODE_W-1:0] MODE_DEQ = 1'b1;

   // data returned by a refused dequeue, and by any enqueue
   localparam logic [DATA_W-1:0] DATA_EMPTY = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] DATA_NONE  = 32'h0000_0000;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

[rtl/mqf_if.sv]
// Valid/ready channel interfaces for the FIFO bank: request and response.
// Depends on mqf_pkg for field widths.
interface mqf_req_if import mqf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [QIDX_W-1:0]        queue_index;
   logic signed [DATA_W-1:0] item;

   modport source (output valid, output mode, output queue_index, output item,
                   input ready);
   modport sink   (input valid, input mode, input queue_index, input item,
                   output ready);
endinterface

interface mqf_rsp_if import mqf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] data;

   modport source (output valid, output status, output data, input ready);
   modport sink   (input valid, input status, input data, output ready);
endinterface

[rtl/multi_queue_fifo_bank.sv]
// Multi-queue FIFO bank: NUM_QUEUES circular FIFOs in one entry memory.
// The response is registered; it is loaded in S_RESP once the output register is free.
// A new request is taken only in S_IDLE, after the previous one has passed the
// pointer memory read, then update/write-back with the entry access, then response load.
// Reset: pointer valid bits clear at once (all queues empty), capacity 16;
// the entry memory is not cleared, no clearing pass is needed.
module multi_queue_fifo_bank import mqf_pkg::*; #(
   parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   mqf_req_if.sink          req_bus,
   mqf_rsp_if.source        rsp_bus
);

   localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT   = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW    = (ENT > 1) ? $clog2(ENT) : 1;
   localparam int RW    = 2 * PW + CW;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DECIDE = 3'b010,
      S_RESP   = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [MODE_W-1:0]   mode_ff;
   logic [QW-1:0]       q_ff, q_in;
   logic [DATA_W-1:0]   item_ff;
   status_type          st_ff, st_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                from_ram_ff, from_ram_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                out_free;
   logic [CW-1:0]       cap_use;
   logic [RW-1:0]       ptr_rd, ptr_wr;
   logic                ptr_we;
   logic [PW-1:0]       head, tail, head_nxt, tail_nxt;
   logic [CW-1:0]       occ, occ_nxt;
   logic [AW-1:0]       head_addr, tail_addr;
   logic                ent_we, ent_re;
   logic [DATA_W-1:0]   ent_rd;

   // next pointer: wraps to 0 once pointer+1 reaches the capacity
   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] inc;
      inc = CW'(p) + CW'(1);
      return (inc >= cap) ? '0 : PW'(inc);
   endfunction

   // queue index folded into range by repeated subtraction
   function automatic logic [QW-1:0] fold_index(input logic [QIDX_W-1:0] idx);
      logic [QIDX_W:0] v;
      v = {1'b0, idx};
      for (int k = 0; k < (1 << QIDX_W); k++) begin
         if (32'(v) >= NUM_QUEUES) begin
            v = v - (QIDX_W+1)'(NUM_QUEUES);
         end
      end
      return QW'(v);
   endfunction

   assign accept      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;

   // capacity in use: zero acts as one, clamp to region size
   always_comb begin
      int c;
      c = 32'(cap_ff);
      if (c == 0) begin
         c = 1;
      end
      if (c > QUEUE_DEPTH) begin
         c = QUEUE_DEPTH;
      end
      cap_use = CW'(c);
   end

   // capacity register
   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end
   end

   // pointer record fields and their updates
   assign {head, tail, occ} = ptr_rd;
   assign head_nxt  = advance(head, cap_use);
   assign tail_nxt  = advance(tail, cap_use);
   assign head_addr = AW'(32'(q_ff) * QUEUE_DEPTH + 32'(head));
   assign tail_addr = AW'(32'(q_ff) * QUEUE_DEPTH + 32'(tail));

   // decide step: full/empty check, write-back and entry access
   always_comb begin
      st_in       = st_ff;
      data_in     = data_ff;
      from_ram_in = from_ram_ff;
      ptr_we      = 1'b0;
      ptr_wr      = ptr_rd;
      occ_nxt     = occ;
      ent_we      = 1'b0;
      ent_re      = 1'b0;
      if (state_ff == S_DECIDE) begin
         from_ram_in = 1'b0;
         if (mode_ff == MODE_ENQ) begin
            data_in = DATA_NONE;
            if (occ >= cap_use) begin
               st_in = ST_FULL;
            end else begin
               st_in   = ST_DONE;
               ent_we  = 1'b1;
               occ_nxt = occ + CW'(1);
               ptr_we  = 1'b1;
               ptr_wr  = {head, tail_nxt, occ_nxt};
            end
         end else begin
            if (occ == '0) begin
               st_in   = ST_EMPTY;
               data_in = DATA_EMPTY;
            end else begin
               st_in       = ST_DONE;
               ent_re      = 1'b1;
               from_ram_in = 1'b1;
               occ_nxt     = occ - CW'(1);
               ptr_we      = 1'b1;
               ptr_wr      = {head_nxt, tail, occ_nxt};
            end
         end
      end
   end

   // sequencer and response register
   always_comb begin
      state_in      = state_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (accept) begin
         q_in = fold_index(req_bus.queue_index);
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_data_in   = from_ram_ff ? ent_rd : data_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_bus.mode;
         item_ff <= req_bus.item;
      end
      q_ff          <= q_in;
      st_ff         <= st_in;
      data_ff       <= data_in;
      from_ram_ff   <= from_ram_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.data   = rsp_data_ff;

   // pointer record memory, read on accept
   mqf_ptr_ram #(
      .ENTRIES (NUM_QUEUES),
      .IW      (QW),
      .RW      (RW)
   ) u_ptr_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ptr_we),
      .wr_addr (q_ff),
      .wr_data (ptr_wr),
      .rd_en   (accept),
      .rd_addr (q_in),
      .rd_data (ptr_rd)
   );

   // entry memory
   mqf_entry_ram #(
      .DEPTH (ENT),
      .AW    (AW),
      .DW    (DATA_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (tail_addr),
      .wr_data (item_ff),
      .rd_en   (ent_re),
      .rd_addr (head_addr),
      .rd_data (ent_rd)
   );

endmodule

[rtl/mqf_entry_ram.sv]
// Entry store of the FIFO bank: single write port, single read port,
// registered read data. No dependencies; contents are not reset.
module mqf_entry_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mqf_ptr_ram.sv]
// Per-queue pointer record store (head, tail, occupancy packed): one
// write and one read port, registered read, valid bits so reset reads zero.
module mqf_ptr_ram #(
   parameter int ENTRIES = 8,
   parameter int IW      = 3,
   parameter int RW      = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [RW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic [RW-1:0] rd_data
);

   logic [RW-1:0]      mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [RW-1:0]      rd_word_ff;
   logic               rd_valid_ff;
   logic               rd_valid_in;

   // record array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // valid bits: cleared by reset, set on first write
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // read valid with write-first forwarding on a same-entry collision
   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr] || (wr_en && (wr_addr == rd_addr));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_word_ff <= wr_data;
         end else begin
            rd_word_ff <= mem[rd_addr];
         end
      end
   end

   // an entry never written reads as zero
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule
